[rtl/rti_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg: shared constants of the ray/triangle intersection unit
// Register indexes of the configuration port and the widths of the
// threshold registers.
// ----------------------------------------------------------------------------
package rti_pkg;

    // Configuration port index width
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_T   = 3'd4;

    // Threshold register widths
    localparam int MIN_DET_W = 20;
    localparam int MIN_T_W   = 19;

endpackage

`default_nettype wire

[rtl/ray_triangle_intersect_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect_unit: pipelined ray/triangle intersection
// Tests each incoming ray against the configured triangle and returns hit,
// unsigned fixed-point distance t and signed fixed-point hit point.
//
// Usage:
//   Write the three vertices, min_det and min_t on the configuration port
//   while no item is in flight. Rays enter on the s_axis channel
//   (tdata: origin x, y, z, dir x, y, z from the lowest bit up); results
//   leave on the m_axis channel (tuser: hit; tdata: distance, point x, y, z).
//   The pipeline has five stages of cross and dot products, one check
//   stage, COORD_BITS-1 divider stages that each settle one quotient bit,
//   and two stages for the hit point. Throughput is one ray per cycle
//   while the receiver does not stall, set by the pipelined divider.
//   Reset empties the pipeline and loads the register reset values
//   (vertices 0, min_det 1, min_t 1). When the receiver stalls, each stage
//   still takes an item while it is empty, so bubbles close up; the input
//   is held off only once every stage holds an item.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_unit #(
    parameter int COORD_BITS = 20,
    parameter int FRAC_BITS  = 12
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Configuration write port
    input  wire                              i_cfg_we,
    input  wire  [rti_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [3*COORD_BITS-1:0]          i_cfg_data,
    // Ray input: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire  [((6*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // Result: tdata holds distance, point_x, point_y, point_z; tuser holds hit
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    output logic [((4*COORD_BITS-1+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                             o_m_axis_tuser
);
    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int DW = 2 * C + 2 - F + C + 1 + 3 + 1;
    localparam int OW = ((4 * C - 1 + 7) / 8) * 8;
    localparam int XW = (C - 1 > rti_pkg::MIN_T_W) ? C - 1 : rti_pkg::MIN_T_W;

    // Configuration registers
    logic [3*C-1:0]                  r_vtx0, r_vtx1, r_vtx2;
    logic [rti_pkg::MIN_DET_W-1:0]   r_min_det;
    logic [rti_pkg::MIN_T_W-1:0]     r_min_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx0    <= '0;
            r_vtx1    <= '0;
            r_vtx2    <= '0;
            r_min_det <= rti_pkg::MIN_DET_W'(1);
            r_min_t   <= rti_pkg::MIN_T_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rti_pkg::REG_VERTEX0: begin
                    r_vtx0 <= i_cfg_data;
                end
                rti_pkg::REG_VERTEX1: begin
                    r_vtx1 <= i_cfg_data;
                end
                rti_pkg::REG_VERTEX2: begin
                    r_vtx2 <= i_cfg_data;
                end
                rti_pkg::REG_MIN_DET: begin
                    r_min_det <= i_cfg_data[rti_pkg::MIN_DET_W-1:0];
                end
                rti_pkg::REG_MIN_T: begin
                    r_min_t <= i_cfg_data[rti_pkg::MIN_T_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end: products and determinant
    logic                 w_f_valid, w_f_ready;
    logic signed [DW-1:0] w_f_det, w_f_uu, w_f_vv, w_f_tt;
    logic [3*C-1:0]       w_f_org, w_f_dir;

    rti_front #(.C(C), .F(F)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx0  (r_vtx0),
        .i_vtx1  (r_vtx1),
        .i_vtx2  (r_vtx2),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_org   (i_s_axis_tdata[3*C-1:0]),
        .i_dir   (i_s_axis_tdata[6*C-1:3*C]),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_det   (w_f_det),
        .o_uu    (w_f_uu),
        .o_vv    (w_f_vv),
        .o_tt    (w_f_tt),
        .o_org   (w_f_org),
        .o_dir   (w_f_dir)
    );

    // Inside test and divider
    logic           w_d_valid, w_d_ready, w_d_hit;
    logic [C-2:0]   w_d_t;
    logic [3*C-1:0] w_d_org, w_d_dir;

    rti_div #(.C(C), .F(F)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_min_det (r_min_det),
        .i_valid   (w_f_valid),
        .o_ready   (w_f_ready),
        .i_det     (w_f_det),
        .i_uu      (w_f_uu),
        .i_vv      (w_f_vv),
        .i_tt      (w_f_tt),
        .i_org     (w_f_org),
        .i_dir     (w_f_dir),
        .o_valid   (w_d_valid),
        .i_ready   (w_d_ready),
        .o_hit     (w_d_hit),
        .o_t       (w_d_t),
        .o_org     (w_d_org),
        .o_dir     (w_d_dir)
    );

    // Hit point and output register
    logic           w_b_hit;
    logic [C-2:0]   w_b_t;
    logic [3*C-1:0] w_b_point;

    rti_back #(.C(C), .F(F)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_min_t (r_min_t),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_hit   (w_d_hit),
        .i_t     (w_d_t),
        .i_org   (w_d_org),
        .i_dir   (w_d_dir),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_hit   (w_b_hit),
        .o_t     (w_b_t),
        .o_point (w_b_point)
    );

    assign o_m_axis_tdata = OW'({w_b_point, w_b_t});
    assign o_m_axis_tuser = w_b_hit;

    // A miss carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("miss result with nonzero fields");

    // A hit never reports a distance below min_t
    a_hit_min_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser
        |-> XW'(o_m_axis_tdata[C-2:0]) >= XW'(r_min_t))
        else $error("hit below minimum distance");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

[rtl/rti_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_front: edge vectors, cross products and dot products
// Five stages: edges, cross partial products, cross differences, dot
// partial products, dot sums with sign correction of the determinant.
// ----------------------------------------------------------------------------
module rti_front #(
    parameter int C = 20,
    parameter int F = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  [3*C-1:0]       i_vtx0,
    input  wire  [3*C-1:0]       i_vtx1,
    input  wire  [3*C-1:0]       i_vtx2,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [3*C-1:0]       i_org,
    input  wire  [3*C-1:0]       i_dir,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic signed [2*C+2-F+C+1+3-1+1:0] o_det,
    output logic signed [2*C+2-F+C+1+3-1+1:0] o_uu,
    output logic signed [2*C+2-F+C+1+3-1+1:0] o_vv,
    output logic signed [2*C+2-F+C+1+3-1+1:0] o_tt,
    output logic [3*C-1:0]       o_org,
    output logic [3*C-1:0]       o_dir
);
    localparam int EW  = C + 1;
    localparam int PW  = 2 * C + 3;
    localparam int QW  = PW - F;
    localparam int MW  = EW + QW;
    localparam int DW  = MW + 3;
    localparam int NST = 5;

    // Handshake chain: a stage loads when it is empty or its successor moves
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_adv;

    always_comb begin
        w_adv[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Origin and direction travel with the item
    logic [3*C-1:0] r_org [NST];
    logic [3*C-1:0] r_dir [NST];

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_org[0] <= i_org;
            r_dir[0] <= i_dir;
        end
        for (int k = 1; k < NST; k++) begin
            if (w_adv[k]) begin
                r_org[k] <= r_org[k-1];
                r_dir[k] <= r_dir[k-1];
            end
        end
    end

    // Stage A: edges e1, e2 and origin offset s
    logic signed [EW-1:0] n_e1 [3];
    logic signed [EW-1:0] n_e2 [3];
    logic signed [EW-1:0] n_s  [3];
    logic signed [EW-1:0] r_a_e1 [3];
    logic signed [EW-1:0] r_a_e2 [3];
    logic signed [EW-1:0] r_a_s  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_e1[c] = EW'($signed(i_vtx1[c*C +: C])) - EW'($signed(i_vtx0[c*C +: C]));
            n_e2[c] = EW'($signed(i_vtx2[c*C +: C])) - EW'($signed(i_vtx0[c*C +: C]));
            n_s[c]  = EW'($signed(i_org[c*C +: C]))  - EW'($signed(i_vtx0[c*C +: C]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_a_e1 <= n_e1;
            r_a_e2 <= n_e2;
            r_a_s  <= n_s;
        end
    end

    // Stage B: partial products of h = dir x e2 and q = s x e1
    logic signed [C-1:0]  w_a_dir [3];
    logic signed [PW-1:0] n_ha [3];
    logic signed [PW-1:0] n_hb [3];
    logic signed [PW-1:0] n_qa [3];
    logic signed [PW-1:0] n_qb [3];
    logic signed [PW-1:0] r_b_ha [3];
    logic signed [PW-1:0] r_b_hb [3];
    logic signed [PW-1:0] r_b_qa [3];
    logic signed [PW-1:0] r_b_qb [3];
    logic signed [EW-1:0] r_b_e1 [3];
    logic signed [EW-1:0] r_b_e2 [3];
    logic signed [EW-1:0] r_b_s  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_a_dir[c] = $signed(r_dir[0][c*C +: C]);
        end
        n_ha[0] = w_a_dir[1] * r_a_e2[2];
        n_hb[0] = w_a_dir[2] * r_a_e2[1];
        n_ha[1] = w_a_dir[2] * r_a_e2[0];
        n_hb[1] = w_a_dir[0] * r_a_e2[2];
        n_ha[2] = w_a_dir[0] * r_a_e2[1];
        n_hb[2] = w_a_dir[1] * r_a_e2[0];
        n_qa[0] = r_a_s[1] * r_a_e1[2];
        n_qb[0] = r_a_s[2] * r_a_e1[1];
        n_qa[1] = r_a_s[2] * r_a_e1[0];
        n_qb[1] = r_a_s[0] * r_a_e1[2];
        n_qa[2] = r_a_s[0] * r_a_e1[1];
        n_qb[2] = r_a_s[1] * r_a_e1[0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_b_ha <= n_ha;
            r_b_hb <= n_hb;
            r_b_qa <= n_qa;
            r_b_qb <= n_qb;
            r_b_e1 <= r_a_e1;
            r_b_e2 <= r_a_e2;
            r_b_s  <= r_a_s;
        end
    end

    // Stage C: cross differences, floored back to F fraction bits
    logic signed [PW-1:0] w_hd [3];
    logic signed [PW-1:0] w_qd [3];
    logic signed [QW-1:0] r_c_h [3];
    logic signed [QW-1:0] r_c_q [3];
    logic signed [EW-1:0] r_c_e1 [3];
    logic signed [EW-1:0] r_c_e2 [3];
    logic signed [EW-1:0] r_c_s  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_hd[c] = r_b_ha[c] - r_b_hb[c];
            w_qd[c] = r_b_qa[c] - r_b_qb[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            for (int c = 0; c < 3; c++) begin
                r_c_h[c] <= $signed(w_hd[c][PW-1:F]);
                r_c_q[c] <= $signed(w_qd[c][PW-1:F]);
            end
            r_c_e1 <= r_b_e1;
            r_c_e2 <= r_b_e2;
            r_c_s  <= r_b_s;
        end
    end

    // Stage D: partial products of det, U, V and T
    logic signed [C-1:0]  w_c_dir [3];
    logic signed [MW-1:0] n_pd [3];
    logic signed [MW-1:0] n_pu [3];
    logic signed [MW-1:0] n_pv [3];
    logic signed [MW-1:0] n_pt [3];
    logic signed [MW-1:0] r_d_pd [3];
    logic signed [MW-1:0] r_d_pu [3];
    logic signed [MW-1:0] r_d_pv [3];
    logic signed [MW-1:0] r_d_pt [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_c_dir[c] = $signed(r_dir[2][c*C +: C]);
            n_pd[c] = r_c_e1[c] * r_c_h[c];
            n_pu[c] = r_c_s[c] * r_c_h[c];
            n_pv[c] = w_c_dir[c] * r_c_q[c];
            n_pt[c] = r_c_e2[c] * r_c_q[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_d_pd <= n_pd;
            r_d_pu <= n_pu;
            r_d_pv <= n_pv;
            r_d_pt <= n_pt;
        end
    end

    // Stage E: dot sums, then make the determinant non-negative
    logic signed [DW-1:0] w_det, w_uu, w_vv, w_tt;
    logic signed [DW-1:0] r_e_det, r_e_uu, r_e_vv, r_e_tt;

    always_comb begin
        w_det = DW'(r_d_pd[0]) + DW'(r_d_pd[1]) + DW'(r_d_pd[2]);
        w_uu  = DW'(r_d_pu[0]) + DW'(r_d_pu[1]) + DW'(r_d_pu[2]);
        w_vv  = DW'(r_d_pv[0]) + DW'(r_d_pv[1]) + DW'(r_d_pv[2]);
        w_tt  = DW'(r_d_pt[0]) + DW'(r_d_pt[1]) + DW'(r_d_pt[2]);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            if (w_det[DW-1]) begin
                r_e_det <= -w_det;
                r_e_uu  <= -w_uu;
                r_e_vv  <= -w_vv;
                r_e_tt  <= -w_tt;
            end else begin
                r_e_det <= w_det;
                r_e_uu  <= w_uu;
                r_e_vv  <= w_vv;
                r_e_tt  <= w_tt;
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NST-1];
    assign o_det   = r_e_det;
    assign o_uu    = r_e_uu;
    assign o_vv    = r_e_vv;
    assign o_tt    = r_e_tt;
    assign o_org   = r_org[NST-1];
    assign o_dir   = r_dir[NST-1];

endmodule

`default_nettype wire

[rtl/rti_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_div: inside test and pipelined distance divider
// One stage checks the determinant and barycentric bounds, then C-1
// restoring stages produce one quotient bit each of t = T * 2^F / det.
// ----------------------------------------------------------------------------
module rti_div #(
    parameter int C = 20,
    parameter int F = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  [rti_pkg::MIN_DET_W-1:0] i_min_det,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  signed [2*C+2-F+C+1+3-1+1:0] i_det,
    input  wire  signed [2*C+2-F+C+1+3-1+1:0] i_uu,
    input  wire  signed [2*C+2-F+C+1+3-1+1:0] i_vv,
    input  wire  signed [2*C+2-F+C+1+3-1+1:0] i_tt,
    input  wire  [3*C-1:0]       i_org,
    input  wire  [3*C-1:0]       i_dir,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic                 o_hit,
    output logic [C-2:0]         o_t,
    output logic [3*C-1:0]       o_org,
    output logic [3*C-1:0]       o_dir
);
    localparam int DW = 2 * C + 2 - F + C + 1 + 3 + 1;
    localparam int NW = DW + F;
    localparam int NS = C;
    localparam int XW = (DW > rti_pkg::MIN_DET_W) ? DW : rti_pkg::MIN_DET_W;

    // Handshake chain
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_adv;

    always_comb begin
        w_adv[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    logic [DW-1:0]    r_d   [NS];
    logic [DW-1:0]    r_rem [NS];
    logic [C-2:0]     r_quo [NS];
    logic [C-2:0]     r_low [NS];
    logic             r_hit [NS];
    logic             r_sat [NS];
    logic [3*C-1:0]   r_org [NS];
    logic [3*C-1:0]   r_dir [NS];

    // Check stage: parallel, outside and behind tests, divider setup
    logic [DW-1:0]        w_det_u;
    logic signed [DW:0]   w_uv;
    logic [NW-1:0]        w_num;
    logic [NW-C:0]        w_top;
    logic                 w_hit;
    logic                 w_sat;

    always_comb begin
        w_det_u = i_det;
        w_uv    = (DW+1)'(i_uu) + (DW+1)'(i_vv);
        w_num   = {i_tt, {F{1'b0}}};
        w_top   = w_num[NW-1:C-1];
        w_hit   = (w_det_u != '0) && (XW'(w_det_u) >= XW'(i_min_det))
                  && !i_uu[DW-1] && (i_uu <= i_det) && !i_vv[DW-1]
                  && (w_uv <= (DW+1)'(i_det)) && !i_tt[DW-1];
        // Quotient would not fit C-1 bits: t saturates
        w_sat   = NW'(w_top) >= NW'(w_det_u);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_hit[0] <= w_hit;
            r_sat[0] <= w_sat;
            r_d[0]   <= w_det_u;
            r_rem[0] <= (w_hit && !w_sat) ? DW'(w_top) : '0;
            r_low[0] <= w_num[C-2:0];
            r_quo[0] <= '0;
            r_org[0] <= i_org;
            r_dir[0] <= i_dir;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 1; k < NS; k++) begin : g_step
        logic [DW-1:0] w_tr;
        logic          w_ge;

        always_comb begin
            w_tr = {r_rem[k-1][DW-2:0], r_low[k-1][C-2]};
            w_ge = w_tr >= r_d[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k]) begin
                r_rem[k] <= w_ge ? (w_tr - r_d[k-1]) : w_tr;
                r_quo[k] <= {r_quo[k-1][C-3:0], w_ge};
                r_low[k] <= r_low[k-1] << 1;
                r_d[k]   <= r_d[k-1];
                r_hit[k] <= r_hit[k-1];
                r_sat[k] <= r_sat[k-1];
                r_org[k] <= r_org[k-1];
                r_dir[k] <= r_dir[k-1];
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NS-1];
    assign o_hit   = r_hit[NS-1];
    assign o_t     = r_sat[NS-1] ? '1 : r_quo[NS-1];
    assign o_org   = r_org[NS-1];
    assign o_dir   = r_dir[NS-1];

endmodule

`default_nettype wire

[rtl/rti_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_back: hit point and result register
// Applies the minimum distance, multiplies direction by t, adds the
// origin and saturates each coordinate. The last stage is the output.
// ----------------------------------------------------------------------------
module rti_back #(
    parameter int C = 20,
    parameter int F = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  [rti_pkg::MIN_T_W-1:0] i_min_t,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire                  i_hit,
    input  wire  [C-2:0]         i_t,
    input  wire  [3*C-1:0]       i_org,
    input  wire  [3*C-1:0]       i_dir,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic                 o_hit,
    output logic [C-2:0]         o_t,
    output logic [3*C-1:0]       o_point
);
    localparam int XW = (C - 1 > rti_pkg::MIN_T_W) ? C - 1 : rti_pkg::MIN_T_W;
    localparam int SW = ((2 * C - F > C) ? 2 * C - F : C) + 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (C - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    // Handshake chain over the product stage and the output stage
    logic [1:0] r_vld;
    logic [1:0] w_adv;

    assign w_adv[1] = !r_vld[1] || i_ready;
    assign w_adv[0] = !r_vld[0] || w_adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_adv[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    // Product stage: minimum distance test and direction times t
    logic signed [2*C-1:0] n_prod [3];
    logic signed [2*C-1:0] r_prod [3];
    logic [3*C-1:0]        r_org;
    logic [C-2:0]          r_t;
    logic                  r_hit;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_prod[c] = $signed(i_dir[c*C +: C]) * $signed({1'b0, i_t});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_prod <= n_prod;
            r_org  <= i_org;
            r_t    <= i_t;
            r_hit  <= i_hit && (XW'(i_t) >= XW'(i_min_t));
        end
    end

    // Output stage: add origin, saturate, clear the fields of a miss
    logic signed [SW-1:0] w_sum [3];
    logic [3*C-1:0]       n_point;
    logic [3*C-1:0]       r_out_point;
    logic [C-2:0]         r_out_t;
    logic                 r_out_hit;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = SW'($signed(r_org[c*C +: C])) + SW'($signed(r_prod[c][2*C-1:F]));
            if (!r_hit) begin
                n_point[c*C +: C] = '0;
            end else if (w_sum[c] > SAT_HI) begin
                n_point[c*C +: C] = SAT_HI[C-1:0];
            end else if (w_sum[c] < SAT_LO) begin
                n_point[c*C +: C] = SAT_LO[C-1:0];
            end else begin
                n_point[c*C +: C] = w_sum[c][C-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_out_point <= n_point;
            r_out_t     <= r_hit ? r_t : '0;
            r_out_hit   <= r_hit;
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[1];
    assign o_hit   = r_out_hit;
    assign o_t     = r_out_t;
    assign o_point = r_out_point;

endmodule

`default_nettype wire

[dv/ray_triangle_intersect_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_unit_tb: self-checking bench of the intersector
// Streams rays through the unit against a series of triangles and thresholds.
// A directed table covers extremes and the edge, parallel, behind-origin,
// saturation and minimum-distance cases, then random rays, mostly aimed at
// the triangle, are checked against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_unit_tb;

    localparam int  CB        = 20;
    localparam int  FB        = 12;
    localparam int  N_PHASES  = 5;
    localparam int  PHASE_LEN = 250;
    localparam int  DRAIN     = 40;
    localparam longint TMAX   = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint CMIN   = -(64'sd1 <<< (CB - 1));

    typedef struct packed {
        logic signed [CB-1:0] dz, dy, dx, oz, oy, ox;
    } t_ray;

    typedef struct {
        logic                 hit;
        logic [CB-2:0]        distance;
        logic signed [CB-1:0] px, py, pz;
    } t_isect;

    typedef struct {
        t_ray r;
        bit   typed;  // expectation is a plain miss, typed in
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [rti_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [3*CB-1:0]               i_cfg_data = '0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [6*CB-1:0]               i_s_axis_tdata = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [79:0]                   o_m_axis_tdata;
    logic                          o_m_axis_tuser;

    // Copy of the configuration registers, as seen by the predictor
    logic [3*CB-1:0] vtx [3];
    logic [19:0]     min_det;
    logic [18:0]     min_t;

    t_isect pending_q[$];
    int     n_errors = 0;
    int     n_hits = 0;
    int     n_results = 0;
    int     n_rays = 0;
    bit     quiet = 1'b0;
    int     stall_left = 0;

    ray_triangle_intersect_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // ox, oy, oz, dx, dy, dz
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // distance, point x, y, z
        .o_m_axis_tuser  (o_m_axis_tuser)    // hit
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_ray mkray(longint ox, longint oy, longint oz,
                                   longint dx, longint dy, longint dz);
        t_ray r;
        r.ox = ox[CB-1:0];
        r.oy = oy[CB-1:0];
        r.oz = oz[CB-1:0];
        r.dx = dx[CB-1:0];
        r.dy = dy[CB-1:0];
        r.dz = dz[CB-1:0];
        return r;
    endfunction

    // Cross product of exact Q.2F terms, floored back to Q.F.
    function automatic void cross_floor(input longint a[3], input longint b[3],
                                        output longint r[3]);
        r[0] = (a[1] * b[2] - a[2] * b[1]) >>> FB;
        r[1] = (a[2] * b[0] - a[0] * b[2]) >>> FB;
        r[2] = (a[0] * b[1] - a[1] * b[0]) >>> FB;
    endfunction

    // Moller-Trumbore in exact fixed point against the current triangle.
    function automatic t_isect predict_isect(t_ray r);
        longint v[3][3];
        longint o[3], d[3], e1[3], e2[3], s[3], h[3], q[3];
        longint det, uu, vv, tt, p;
        longint unsigned quo, rem, adet;
        t_isect res;
        res.hit = 1'b0;
        res.distance = '0;
        res.px = '0;
        res.py = '0;
        res.pz = '0;
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                v[k][c] = longint'($signed(vtx[k][c*CB +: CB]));
            end
        end
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        for (int c = 0; c < 3; c++) begin
            e1[c] = v[1][c] - v[0][c];
            e2[c] = v[2][c] - v[0][c];
            s[c]  = o[c] - v[0][c];
        end
        cross_floor(d, e2, h);
        cross_floor(s, e1, q);
        det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
        uu  = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
        vv  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        tt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (det < 0) begin
            det = -det;
            uu  = -uu;
            vv  = -vv;
            tt  = -tt;
        end
        // Parallel ray, or a hit point outside the triangle or behind the origin.
        if (det == 0 || det < longint'(min_det)) return res;
        if (uu < 0 || uu > det || vv < 0 || uu + vv > det || tt < 0) return res;
        // Long division to FB fraction bits, saturating t.
        adet = det;
        quo = longint'(tt) / adet;
        rem = longint'(tt) % adet;
        if (quo > (TMAX >> FB)) begin
            quo = TMAX;
        end else begin
            for (int k = 0; k < FB; k++) begin
                quo = quo << 1;
                rem = rem << 1;
                if (rem >= adet) begin
                    rem = rem - adet;
                    quo = quo | 1;
                end
            end
            if (quo > TMAX) quo = TMAX;
        end
        if (quo < longint'(min_t)) return res;
        res.hit = 1'b1;
        res.distance = quo[CB-2:0];
        for (int c = 0; c < 3; c++) begin
            p = o[c] + ((d[c] * longint'(quo)) >>> FB);
            if (p > TMAX) p = TMAX;
            if (p < CMIN) p = CMIN;
            if (c == 0) res.px = p[CB-1:0];
            else if (c == 1) res.py = p[CB-1:0];
            else res.pz = p[CB-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    endtask

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_isect want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_q.pop_front();
                if (want.hit) n_hits++;
                if (o_m_axis_tuser !== want.hit)
                    report_mismatch("hit", o_m_axis_tuser, want.hit);
                if (o_m_axis_tdata[18:0] !== want.distance)
                    report_mismatch("distance", o_m_axis_tdata[18:0], want.distance);
                if (o_m_axis_tdata[38:19] !== want.px)
                    report_mismatch("point_x", $signed(o_m_axis_tdata[38:19]), want.px);
                if (o_m_axis_tdata[58:39] !== want.py)
                    report_mismatch("point_y", $signed(o_m_axis_tdata[58:39]), want.py);
                if (o_m_axis_tdata[78:59] !== want.pz)
                    report_mismatch("point_z", $signed(o_m_axis_tdata[78:59]), want.pz);
            end
        end
    end

    // Receiver back-pressure in random bursts.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic [rti_pkg::CFG_IDX_W-1:0] idx, logic [3*CB-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rti_pkg::REG_VERTEX0) vtx[0] = value;
        else if (idx == rti_pkg::REG_VERTEX1) vtx[1] = value;
        else if (idx == rti_pkg::REG_VERTEX2) vtx[2] = value;
        else if (idx == rti_pkg::REG_MIN_DET) min_det = value[19:0];
        else if (idx == rti_pkg::REG_MIN_T) min_t = value[18:0];
    endtask

    task automatic load_triangle(logic [3*CB-1:0] a, logic [3*CB-1:0] b,
                                 logic [3*CB-1:0] c, logic [19:0] det_floor,
                                 logic [18:0] t_floor);
        write_reg(rti_pkg::REG_VERTEX0, a);
        write_reg(rti_pkg::REG_VERTEX1, b);
        write_reg(rti_pkg::REG_VERTEX2, c);
        write_reg(rti_pkg::REG_MIN_DET, 60'(det_floor));
        write_reg(rti_pkg::REG_MIN_T, 60'(t_floor));
    endtask

    // Waits for every expected result, then for the pipeline to empty.
    task automatic drain_results();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Offers one ray and records its expectation once it is accepted.
    task automatic send_ray(t_ray r, bit typed_miss);
        t_isect want;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= r;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_rays++;
        if (typed_miss) begin
            want.hit = 1'b0;
            want.distance = '0;
            want.px = '0;
            want.py = '0;
            want.pz = '0;
        end else begin
            want = predict_isect(r);
        end
        pending_q.push_back(want);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end else if (!quiet && $urandom_range(0, 199) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            while (pending_q.size() != 0) @(posedge i_clk);
        end
    endtask

    function automatic logic [3*CB-1:0] pack_vertex(longint x, longint y, longint z);
        return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
    endfunction

    function automatic longint small_coord();
        return longint'($urandom_range(0, 1 << 18)) - (1 << 17);
    endfunction

    // Random ray, mostly aimed at a point of the triangle, sometimes noise.
    function automatic t_ray random_ray();
        longint v[3][3];
        longint tgt[3], org[3], dvec[3];
        longint a, b;
        int sh;
        if ($urandom_range(0, 9) < 3) begin
            return (6*CB)'({$urandom(), $urandom(), $urandom(), $urandom()});
        end
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                v[k][c] = longint'($signed(vtx[k][c*CB +: CB]));
            end
        end
        a = $urandom_range(0, 4096);
        b = $urandom_range(0, 4096 - a);
        if ($urandom_range(0, 7) == 0) a = 0;
        if ($urandom_range(0, 7) == 0) b = 4096 - a;
        if ($urandom_range(0, 9) == 0) a = a + 600;
        sh = $urandom_range(0, 3);
        for (int c = 0; c < 3; c++) begin
            tgt[c] = v[0][c] + (a * (v[1][c] - v[0][c]) + b * (v[2][c] - v[0][c])) / 4096;
            org[c] = tgt[c] + longint'($urandom_range(0, 1 << 17)) - (1 << 16);
            if (org[c] > TMAX) org[c] = TMAX;
            if (org[c] < CMIN) org[c] = CMIN;
            dvec[c] = (tgt[c] - org[c]) >>> sh;
            if (dvec[c] > TMAX) dvec[c] = TMAX;
            if (dvec[c] < CMIN) dvec[c] = CMIN;
        end
        return mkray(org[0], org[1], org[2], dvec[0], dvec[1], dvec[2]);
    endfunction

    // Stimulus
    initial begin
        t_dir_row rows[$];
        logic [3*CB-1:0] va, vb, vc;
        int n_reset_rows;
        for (int k = 0; k < 3; k++) vtx[k] = '0;
        min_det = 20'd1;
        min_t = 19'd1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Degenerate triangle after reset: every ray misses.
        rows.push_back('{mkray(0, 0, 0, 0, 0, 0), 1'b1});
        rows.push_back('{mkray(TMAX, TMAX, TMAX, TMAX, TMAX, TMAX), 1'b1});
        rows.push_back('{mkray(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1'b1});
        rows.push_back('{mkray(4096, -4096, 8192, 0, 0, -4096), 1'b1});
        n_reset_rows = rows.size();
        // Right triangle in the z = 0 plane, 4.0 on a side.
        rows.push_back('{mkray(4096, 4096, 16384, 0, 0, -4096), 1'b0});     // plain hit
        rows.push_back('{mkray(0, 4096, 16384, 0, 0, -4096), 1'b0});        // on an edge
        rows.push_back('{mkray(16384, 0, 16384, 0, 0, -4096), 1'b0});       // at a vertex
        rows.push_back('{mkray(8192, 8192, 16384, 0, 0, -4096), 1'b0});     // on the hypotenuse
        rows.push_back('{mkray(20000, 20000, 16384, 0, 0, -4096), 1'b0});   // outside
        rows.push_back('{mkray(-4096, 4096, 16384, 0, 0, -4096), 1'b0});    // outside, negative
        rows.push_back('{mkray(4096, 4096, 16384, 4096, 0, 0), 1'b0});      // parallel
        rows.push_back('{mkray(4096, 4096, 16384, 0, 0, 4096), 1'b0});      // behind origin
        rows.push_back('{mkray(4096, 4096, -16384, 0, 0, 4096), 1'b0});     // from below
        rows.push_back('{mkray(4096, 4096, 16384, 0, 0, -1), 1'b0});        // huge t
        rows.push_back('{mkray(4096, 4096, 1, 0, 0, -4096), 1'b0});         // tiny t
        rows.push_back('{mkray(4096, 4096, 0, 0, 0, -4096), 1'b0});         // origin on plane
        rows.push_back('{mkray(4096, 4096, TMAX, 0, 0, CMIN), 1'b0});
        rows.push_back('{mkray(4096, 4096, TMAX, TMAX, TMAX, CMIN), 1'b0});
        rows.push_back('{mkray(CMIN, CMIN, TMAX, TMAX, TMAX, CMIN), 1'b0});
        rows.push_back('{mkray(2048, 2048, 4096, 1, 1, -4096), 1'b0});
        for (int i = 0; i < rows.size(); i++) begin
            if (i == n_reset_rows) begin
                i_s_axis_tvalid <= 1'b0;
                drain_results();
                load_triangle(pack_vertex(0, 0, 0), pack_vertex(16384, 0, 0),
                              pack_vertex(0, 16384, 0), 20'd1, 19'd1);
            end
            send_ray(rows[i].r, rows[i].typed);
        end

        // Random phases, each with its own triangle and thresholds.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            i_s_axis_tvalid <= 1'b0;
            drain_results();
            va = pack_vertex(small_coord(), small_coord(), small_coord());
            vb = pack_vertex(small_coord(), small_coord(), small_coord());
            vc = pack_vertex(small_coord(), small_coord(), small_coord());
            case (ph)
                0: load_triangle(va, vb, vc, 20'd1, 19'd1);
                1: load_triangle(va, vb, vc, 20'd0, 19'd0);
                2: load_triangle(va, vb, vc, 20'hFFFFF, 19'h7FFFF);
                3: load_triangle(60'({$urandom(), $urandom()}), 60'({$urandom(), $urandom()}),
                                 60'({$urandom(), $urandom()}), 20'($urandom()),
                                 19'($urandom_range(0, 8192)));
                default: begin
                    quiet = 1'b1;
                    load_triangle(va, vb, vc, 20'd1, 19'd1);
                end
            endcase
            for (int n = 0; n < PHASE_LEN; n++) begin
                send_ray(random_ray(), 1'b0);
            end
        end
        i_s_axis_tvalid <= 1'b0;
        drain_results();

        $display("Sent %0d rays over %0d triangle settings; %0d results, %0d of them hits.",
                 n_rays, N_PHASES + 2, n_results, n_hits);
        if (n_errors == 0 && pending_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
rtl/rti_pkg.sv
rtl/rti_front.sv
rtl/rti_div.sv
rtl/rti_back.sv
rtl/ray_triangle_intersect_unit.sv
dv/ray_triangle_intersect_unit_tb.sv
